@@ hw/rtl/qfts_pkg.sv @@
// qfts_pkg: shared types and constants for the two-stack queue
// used by the channel interfaces and every module of the block
package qfts_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_ENQ  = 2'd0;
  localparam kind_t KIND_DEQ  = 2'd1;
  localparam kind_t KIND_PEEK = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

@@ hw/rtl/qfts_in_if.sv @@
// qfts_in_if: request channel of the two-stack queue (operation and word)
// depends on qfts_pkg
interface qfts_in_if;
  logic                                valid;
  logic                                ready;
  qfts_pkg::kind_t                     kind;
  logic signed [qfts_pkg::DATA_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

@@ hw/rtl/qfts_out_if.sv @@
// qfts_out_if: response channel of the two-stack queue (word and status)
// depends on qfts_pkg
interface qfts_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qfts_pkg::DATA_W-1:0]  data;
  qfts_pkg::status_t                   status;

  modport source (output valid, output data, output status, input ready);
  modport sink   (input valid, input data, input status, output ready);
endinterface

@@ hw/rtl/queue_from_two_stacks.sv @@
// queue_from_two_stacks: fifo queue built from an inbox and an outbox stack
// depends on qfts_pkg, qfts_in_if, qfts_out_if and qfts_ram
//
//   channel  dir  fields           meaning
//   req      in   kind, value      0 enqueue, 1 dequeue, 2 peek; word to push
//   rsp      out  data, status     read word or zero; 0 ok, 1 full, 2 empty
//
// enqueue, refused requests and unused kinds: answered straight from idle
// dequeue/peek with a filled outbox: outbox read, then response
// dequeue/peek with an empty outbox: first the refill that moves one entry
//   per cycle through the inbox read port, then outbox read and response
// reset clears both counts and the control state; the stores are never cleared
// a request is taken only in idle while the response register is free or
//   being drained in the same cycle
module queue_from_two_stacks #(
  parameter int DEPTH = qfts_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  qfts_in_if.sink     req,
  qfts_out_if.source  rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = qfts_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_LOOK,
    S_FETCH
  } state_t;

  state_t                state;
  logic [CW-1:0]         in_cnt;
  logic [CW-1:0]         out_cnt;
  logic                  mv_pend;
  logic                  op_deq;
  logic                  out_valid;
  logic signed [DW-1:0]  out_data;
  qfts_pkg::status_t     out_status;

  logic                  take;
  logic                  out_free;
  logic                  in_full;
  logic                  q_empty;
  logic                  is_read;
  logic                  rsp_load;
  logic [CW-1:0]         in_cnt_dec;
  logic [CW-1:0]         out_cnt_dec;

  logic                  ib_we;
  logic [AW-1:0]         ib_waddr;
  logic [DW-1:0]         ib_wdata;
  logic                  ib_re;
  logic [AW-1:0]         ib_raddr;
  logic [DW-1:0]         ib_rdata;

  logic                  ob_we;
  logic [AW-1:0]         ob_waddr;
  logic                  ob_re;
  logic [AW-1:0]         ob_raddr;
  logic [DW-1:0]         ob_rdata;

  always_comb begin
    out_free    = !out_valid || rsp.ready;
    req.ready   = (state == S_IDLE) && out_free;
    take        = req.valid && req.ready;
    in_full     = (in_cnt == CW'(DEPTH));
    q_empty     = (in_cnt == '0) && (out_cnt == '0);
    in_cnt_dec  = in_cnt - CW'(1);
    out_cnt_dec = out_cnt - CW'(1);
    is_read     = (req.kind == qfts_pkg::KIND_DEQ) || (req.kind == qfts_pkg::KIND_PEEK);
    // response register gets a new transfer this cycle
    rsp_load    = (take && !(is_read && !q_empty)) || ((state == S_FETCH) && out_free);

    // push goes straight into the inbox store
    ib_we    = take && (req.kind == qfts_pkg::KIND_ENQ) && !in_full;
    ib_waddr = in_cnt[AW-1:0];
    ib_wdata = req.value;

    // refill: read inbox top each cycle, write the word in the next cycle
    ib_re    = (state == S_MOVE) && (in_cnt != '0);
    ib_raddr = in_cnt_dec[AW-1:0];
    ob_we    = (state == S_MOVE) && mv_pend;
    ob_waddr = out_cnt[AW-1:0];

    ob_re    = (state == S_LOOK);
    ob_raddr = out_cnt_dec[AW-1:0];
  end

  qfts_ram #(.DEPTH(DEPTH), .WIDTH(DW)) u_inbox (
    .clk   (clk),
    .we    (ib_we),
    .waddr (ib_waddr),
    .wdata (ib_wdata),
    .re    (ib_re),
    .raddr (ib_raddr),
    .rdata (ib_rdata)
  );

  qfts_ram #(.DEPTH(DEPTH), .WIDTH(DW)) u_outbox (
    .clk   (clk),
    .we    (ob_we),
    .waddr (ob_waddr),
    .wdata (ib_rdata),
    .re    (ob_re),
    .raddr (ob_raddr),
    .rdata (ob_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_cnt    <= '0;
      out_cnt   <= '0;
      mv_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !rsp_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            op_deq <= (req.kind == qfts_pkg::KIND_DEQ);
            case (req.kind)
              qfts_pkg::KIND_ENQ: begin
                out_valid <= 1'b1;
                out_data  <= '0;
                if (in_full) begin
                  out_status <= qfts_pkg::ST_FULL;
                end else begin
                  out_status <= qfts_pkg::ST_OK;
                  in_cnt     <= in_cnt + CW'(1);
                end
              end
              qfts_pkg::KIND_DEQ, qfts_pkg::KIND_PEEK: begin
                if (q_empty) begin
                  out_valid  <= 1'b1;
                  out_data   <= '0;
                  out_status <= qfts_pkg::ST_EMPTY;
                end else if (out_cnt == '0) begin
                  mv_pend <= 1'b0;
                  state   <= S_MOVE;
                end else begin
                  state <= S_LOOK;
                end
              end
              default: begin
                out_valid  <= 1'b1;
                out_data   <= '0;
                out_status <= qfts_pkg::ST_OK;
              end
            endcase
          end
        end
        S_MOVE: begin
          if (in_cnt != '0) begin
            in_cnt <= in_cnt_dec;
          end
          if (mv_pend) begin
            out_cnt <= out_cnt + CW'(1);
          end
          mv_pend <= (in_cnt != '0);
          if ((in_cnt == '0) && !mv_pend) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          // wait here with the read word held until the response slot frees
          if (out_free) begin
            out_valid  <= 1'b1;
            out_data   <= ob_rdata;
            out_status <= qfts_pkg::ST_OK;
            if (op_deq) begin
              out_cnt <= out_cnt_dec;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;

endmodule

@@ hw/rtl/qfts_ram.sv @@
// qfts_ram: one stack store, one write port and one read port
// read data is registered and holds while no read is issued
module qfts_ram #(
  parameter int DEPTH = qfts_pkg::DEPTH_DEF,
  parameter int WIDTH = qfts_pkg::DATA_W
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
